/* hw/rtl/camera_follow_smooth_clamp_top_assert.svh */
// Assertion macros shared by the view tracker RTL.
`ifndef CAMERA_FOLLOW_SMOOTH_CLAMP_TOP_ASSERT_SVH
`define CAMERA_FOLLOW_SMOOTH_CLAMP_TOP_ASSERT_SVH

// Condition must hold at every edge outside reset
`define CFSC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define CFSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent implies consequent at the same edge
`define CFSC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cfsc_pkg.sv */
package cfsc_pkg;

   // Blend table depth and index width
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);

   // Field widths
   localparam int COORD_W = 24;
   localparam int SIZE_W  = 23;
   localparam int RATE_W  = 16;
   localparam int DT_W    = 16;
   localparam int BLEND_W = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(65536);
   localparam logic [15:0]        ZOOM_MIN  = 16'd3;

   // Command codes
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_SET_POS = 2'd1,
      OP_SET_TGT = 2'd2,
      OP_CLR_TGT = 2'd3
   } opcode_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FOLLOW_RATE   = 3'd0,
      REG_ZOOM_FACTOR   = 3'd1,
      REG_BASE_WIDTH    = 3'd2,
      REG_BASE_HEIGHT   = 3'd3,
      REG_BOUNDS_LEFT   = 3'd4,
      REG_BOUNDS_TOP    = 3'd5,
      REG_BOUNDS_WIDTH  = 3'd6,
      REG_BOUNDS_HEIGHT = 3'd7
   } reg_index_type;

   // Sequencer states
   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_MVW   = 11'b000_0000_0010,
      ST_MVH   = 11'b000_0000_0100,
      ST_MRATE = 11'b000_0000_1000,
      ST_LOOK  = 11'b000_0001_0000,
      ST_MAX   = 11'b000_0010_0000,
      ST_MAY   = 11'b000_0100_0000,
      ST_UPY   = 11'b000_1000_0000,
      ST_CLX   = 11'b001_0000_0000,
      ST_CLY   = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

   // Operands for the shared multiplier
   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef logic [EXP_TABLE_DEPTH-1:0][BLEND_W-1:0] blend_tab_type;

   // Build the blend table: entry i holds 1 - exp(-i*s) in Q1.16
   function automatic blend_tab_type build_blend_table();
      blend_tab_type     tab;
      longint unsigned   s;
      longint unsigned   term;
      longint unsigned   pos;
      longint unsigned   neg;
      longint unsigned   q;
      longint unsigned   e;
      int                i;
      s    = (64'd16 << 30) / EXP_TABLE_DEPTH;
      term = 64'd1 << 30;
      pos  = term;
      neg  = 64'd0;
      for (i = 1; i <= 24; i++) begin
         term = ((term * s) >> 30) / 64'(i);
         if (i % 2 == 1) neg = neg + term;
         else            pos = pos + term;
      end
      q = (neg > pos) ? 64'd0 : pos - neg;
      e = 64'd1 << 30;
      for (i = 0; i < EXP_TABLE_DEPTH; i++) begin
         tab[i] = BLEND_W'(64'd65536 - ((e + 64'd8192) >> 14));
         e      = (e * q + (64'd1 << 29)) >> 30;
      end
      return tab;
   endfunction

   localparam blend_tab_type BLEND_TAB = build_blend_table();

endpackage

/* hw/rtl/camera_follow_smooth_clamp_top.sv */
// View centre tracker. Each request word is one command (tick, set position, set target,
// clear target) and yields exactly one response word with the view centre after the
// command and the zoomed view size. Whatever the command, the word passes through every
// step below; the response word is loaded as the sequencer returns to idle, and the next
// word can be accepted from then on. A small sequencer runs one shared 25x17
// multiplier five times (view width, view height, rate times elapsed time, then one
// blend product per axis), with one table lookup step, one step to write back the second
// axis, one clamp step per axis and one step to load the response.
// The request side is not ready while a word is being worked on; a finished response
// waits in its own register, so the next word is taken while it is still unclaimed.
// A response that is still unclaimed when the next one is done holds the sequencer in
// its last step. Configuration writes take effect at once and belong between words.
`include "camera_follow_smooth_clamp_top_assert.svh"

module camera_follow_smooth_clamp_top
   import cfsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [71:0]           req_tdata,  // coord_x, coord_y, delta_time, clamp_enable, pad
   input  logic [1:0]            req_tuser,  // opcode
   // Response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,  // center_x, center_y, view_width, view_height, pad
   // Register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [RATE_W-1:0]         follow_rate_ff;
   logic [15:0]               zoom_factor_ff;
   logic [SIZE_W-1:0]         base_width_ff;
   logic [SIZE_W-1:0]         base_height_ff;
   logic signed [COORD_W-1:0] bounds_left_ff;
   logic signed [COORD_W-1:0] bounds_top_ff;
   logic [SIZE_W-1:0]         bounds_width_ff;
   logic [SIZE_W-1:0]         bounds_height_ff;

   // Tracker state
   logic signed [COORD_W-1:0] cur_x_ff;
   logic signed [COORD_W-1:0] cur_y_ff;
   logic signed [COORD_W-1:0] tgt_x_ff;
   logic signed [COORD_W-1:0] tgt_y_ff;
   logic                      follow_ff;

   // Per-word working registers
   state_type                 state_ff;
   state_type                 state_in;
   logic [DT_W-1:0]           dt_ff;
   logic                      clamp_ff;
   logic                      tick_ff;
   logic [SIZE_W-1:0]         vw_ff;
   logic [SIZE_W-1:0]         vh_ff;
   logic [BLEND_W-1:0]        blend_ff;
   logic                      neg_ff;

   // Response register
   logic                      rsp_valid_ff;
   logic [95:0]               rsp_data_ff;

   // Request fields
   opcode_type                req_op;
   logic signed [COORD_W-1:0] req_x;
   logic signed [COORD_W-1:0] req_y;
   logic [DT_W-1:0]           req_dt;
   logic                      req_clamp;
   logic                      req_accept;

   assign req_op     = opcode_type'(req_tuser);
   assign req_x      = req_tdata[23:0];
   assign req_y      = req_tdata[47:24];
   assign req_dt     = req_tdata[63:48];
   assign req_clamp  = req_tdata[64];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Shared multiplier
   mul_req_type        mul_req;
   logic [MUL_P_W-1:0] mul_prod;

   cfsc_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   // Effective zoom with its floor
   logic [15:0] zoom_eff;
   assign zoom_eff = (zoom_factor_ff < ZOOM_MIN) ? ZOOM_MIN : zoom_factor_ff;

   // Difference and magnitude for the axis in work
   logic signed [COORD_W:0]   diff;
   logic [COORD_W:0]          mag;
   logic signed [COORD_W-1:0] sel_cur;
   logic signed [COORD_W-1:0] sel_tgt;

   assign sel_cur = (state_ff == ST_MAX) ? cur_x_ff : cur_y_ff;
   assign sel_tgt = (state_ff == ST_MAX) ? tgt_x_ff : tgt_y_ff;
   assign diff    = (COORD_W+1)'(sel_tgt) - (COORD_W+1)'(sel_cur);
   assign mag     = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);

   // Select multiplier operands by step
   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         ST_MVW: begin
            mul_req.a = MUL_A_W'(base_width_ff);
            mul_req.b = MUL_B_W'(zoom_eff);
         end
         ST_MVH: begin
            mul_req.a = MUL_A_W'(base_height_ff);
            mul_req.b = MUL_B_W'(zoom_eff);
         end
         ST_MRATE: begin
            mul_req.a = MUL_A_W'(follow_rate_ff);
            mul_req.b = MUL_B_W'(dt_ff);
         end
         ST_MAX, ST_MAY: begin
            mul_req.a = MUL_A_W'(mag);
            mul_req.b = blend_ff;
         end
         default: mul_req = '0;
      endcase
   end

   // Round and saturate a view size product
   logic [MUL_P_W:0]   vsum;
   logic [SIZE_W-1:0]  vsize;
   assign vsum  = (MUL_P_W+1)'(mul_prod) + (MUL_P_W+1)'(128);
   assign vsize = (vsum[MUL_P_W:8] > (MUL_P_W-7)'(8388607)) ? SIZE_W'(8388607)
                                                             : vsum[SIZE_W+7:8];

   // Blend lookup from rate times elapsed time
   logic [63:0]        idx_full;
   logic [BLEND_W-1:0] blend_in;
   assign idx_full = (64'(mul_prod[31:0]) * 64'(EXP_TABLE_DEPTH)) >> 28;
   assign blend_in = ((follow_rate_ff == '0) || (idx_full >= 64'(EXP_TABLE_DEPTH)))
                     ? BLEND_ONE : BLEND_TAB[idx_full[IDX_W-1:0]];

   // Rounded step toward the target and the moved coordinate
   logic signed [COORD_W-1:0] sel_cur_upd;
   logic [MUL_P_W:0]          step_sum;
   logic signed [COORD_W+1:0] step;
   logic signed [COORD_W+1:0] moved;
   assign sel_cur_upd = (state_ff == ST_MAY) ? cur_x_ff : cur_y_ff;
   assign step_sum = (MUL_P_W+1)'(mul_prod) + (MUL_P_W+1)'(32768);
   assign step     = (COORD_W+2)'(step_sum[MUL_P_W:16]);
   assign moved    = neg_ff ? ((COORD_W+2)'(sel_cur_upd) - step)
                            : ((COORD_W+2)'(sel_cur_upd) + step);

   // Clamp one axis to the bounds inset by half the view, or centre it on the bounds when the view does not fit
   logic signed [COORD_W-1:0] cl_cur;
   logic signed [COORD_W-1:0] cl_edge;
   logic [SIZE_W-1:0]         cl_size;
   logic [SIZE_W-1:0]         cl_view;
   logic signed [COORD_W+1:0] cl_lo;
   logic signed [COORD_W+1:0] cl_hi;
   logic signed [COORD_W+1:0] cl_raw;
   logic signed [COORD_W-1:0] cl_res;

   assign cl_cur  = (state_ff == ST_CLX) ? cur_x_ff        : cur_y_ff;
   assign cl_edge = (state_ff == ST_CLX) ? bounds_left_ff  : bounds_top_ff;
   assign cl_size = (state_ff == ST_CLX) ? bounds_width_ff : bounds_height_ff;
   assign cl_view = (state_ff == ST_CLX) ? vw_ff           : vh_ff;
   assign cl_lo   = (COORD_W+2)'(cl_edge) + (COORD_W+2)'(cl_view >> 1);
   assign cl_hi   = (COORD_W+2)'(cl_edge) + (COORD_W+2)'(cl_size)
                    - (COORD_W+2)'(cl_view >> 1);

   always_comb begin
      if (cl_size <= cl_view) begin
         cl_raw = (COORD_W+2)'(cl_edge) + (COORD_W+2)'(cl_size >> 1);
      end else if ((COORD_W+2)'(cl_cur) < cl_lo) begin
         cl_raw = cl_lo;
      end else if ((COORD_W+2)'(cl_cur) > cl_hi) begin
         cl_raw = cl_hi;
      end else begin
         cl_raw = (COORD_W+2)'(cl_cur);
      end
      if (cl_raw > (COORD_W+2)'(8388607)) begin
         cl_res = COORD_W'(8388607);
      end else if (cl_raw < -(COORD_W+2)'(8388608)) begin
         cl_res = COORD_W'(-8388608);
      end else begin
         cl_res = cl_raw[COORD_W-1:0];
      end
   end

   // Advance the sequencer
   logic rsp_load;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_MVW;
         ST_MVW:   state_in = ST_MVH;
         ST_MVH:   state_in = ST_MRATE;
         ST_MRATE: state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_MAX;
         ST_MAX:   state_in = ST_MAY;
         ST_MAY:   state_in = ST_UPY;
         ST_UPY:   state_in = ST_CLX;
         ST_CLX:   state_in = ST_CLY;
         ST_CLY:   state_in = ST_OUT;
         ST_OUT:   if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         follow_rate_ff   <= '0;
         zoom_factor_ff   <= 16'd256;
         base_width_ff    <= '0;
         base_height_ff   <= '0;
         bounds_left_ff   <= '0;
         bounds_top_ff    <= '0;
         bounds_width_ff  <= '0;
         bounds_height_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_FOLLOW_RATE:   follow_rate_ff   <= csr_wdata[RATE_W-1:0];
            REG_ZOOM_FACTOR:   zoom_factor_ff   <= csr_wdata[15:0];
            REG_BASE_WIDTH:    base_width_ff    <= csr_wdata[SIZE_W-1:0];
            REG_BASE_HEIGHT:   base_height_ff   <= csr_wdata[SIZE_W-1:0];
            REG_BOUNDS_LEFT:   bounds_left_ff   <= csr_wdata;
            REG_BOUNDS_TOP:    bounds_top_ff    <= csr_wdata;
            REG_BOUNDS_WIDTH:  bounds_width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_BOUNDS_HEIGHT: bounds_height_ff <= csr_wdata[SIZE_W-1:0];
            default:           ;
         endcase
      end
   end

   // Update tracker state: commands on acceptance, motion and clamp in their steps
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         tgt_x_ff  <= '0;
         tgt_y_ff  <= '0;
         follow_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            unique case (req_op)
               OP_SET_POS: begin
                  cur_x_ff <= req_x;
                  cur_y_ff <= req_y;
                  tgt_x_ff <= req_x;
                  tgt_y_ff <= req_y;
               end
               OP_SET_TGT: begin
                  tgt_x_ff  <= req_x;
                  tgt_y_ff  <= req_y;
                  follow_ff <= 1'b1;
               end
               OP_CLR_TGT: follow_ff <= 1'b0;
               default:    ;
            endcase
         end
         if (tick_ff && follow_ff && (state_ff == ST_MAY)) begin
            cur_x_ff <= moved[COORD_W-1:0];
         end
         if (tick_ff && follow_ff && (state_ff == ST_UPY)) begin
            cur_y_ff <= moved[COORD_W-1:0];
         end
         if (tick_ff && clamp_ff && (state_ff == ST_CLX)) begin
            cur_x_ff <= cl_res;
         end
         if (tick_ff && clamp_ff && (state_ff == ST_CLY)) begin
            cur_y_ff <= cl_res;
         end
      end
   end

   // Hold the word's fields and intermediate results
   always_ff @(posedge clock) begin
      if (req_accept) begin
         dt_ff    <= req_dt;
         clamp_ff <= req_clamp;
         tick_ff  <= (req_op == OP_TICK);
      end
      if (state_ff == ST_MVH)   vw_ff    <= vsize;
      if (state_ff == ST_MRATE) vh_ff    <= vsize;
      if (state_ff == ST_LOOK)  blend_ff <= blend_in;
      if ((state_ff == ST_MAX) || (state_ff == ST_MAY)) neg_ff <= diff[COORD_W];
   end

   // Load the response word and drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {2'b00, vh_ff, vw_ff, cur_y_ff, cur_x_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the sequencer and blend path
   `CFSC_ASSERT_ALWAYS(a_state_onehot, $onehot(state_ff), "sequencer state not one-hot")
   `CFSC_ASSERT_NEXT(a_accept_starts, req_accept, state_ff == ST_MVW, "accepted word did not start")
   `CFSC_ASSERT_SAME(a_blend_range, state_ff == ST_MAX, blend_ff <= BLEND_ONE, "blend above one")
   `CFSC_ASSERT_NEXT(a_load_shows, rsp_load, rsp_tvalid && state_ff == ST_IDLE, "response not shown")

endmodule

/* hw/rtl/cfsc_mul.sv */
module cfsc_mul
   import cfsc_pkg::*;
(
   input  logic               clock,
   input  mul_req_type        mul_req,
   output logic [MUL_P_W-1:0] mul_prod
);

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   // Form the product of the selected operands
   assign prod_in = MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule
